/* rtl/sorted_table_binary_search_macros.svh */
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Concurrent assertion wrappers used by the top-level file, which checks itself.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

`define STBS_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define STBS_ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define STBS_ASSERT(name, clk, rstn, prop)

`define STBS_ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

/* rtl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search: package
// Sizes, beat types, opcodes and the search state encoding.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 10;
    localparam int CNT_W       = 11;
    localparam int KEY_FIELD_W = 32;

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                opcode;
        logic [SLOT_W-1:0]      slot;
        logic [KEY_FIELD_W-1:0] key_value;
    } in_beat_t;

    typedef struct packed {
        logic   found;
        count_t match_index;
    } out_beat_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_PROBE2,
        ST_DONE
    } state_t;

endpackage

/* rtl/stbs_search.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search: search engine
// Key memory with a registered read port and the probe sequencer.
// ----------------------------------------------------------------------------
module stbs_search (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  stbs_pkg::in_beat_t   item,
    input  stbs_pkg::count_t     entry_count,
    input  logic                 res_ready,
    output stbs_pkg::eng_status_t status,
    output stbs_pkg::out_beat_t  result
);
    import stbs_pkg::*;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;

    state_t               state_reg,  state_next;
    logic [KEY_WIDTH-1:0] key_reg,    key_next;
    logic [ADDR_W-1:0]    base_reg,   base_next;
    logic [ADDR_W-1:0]    mid_reg,    mid_next;
    logic [LEN_W-1:0]     len_reg,    len_next;
    logic                 found_reg,  found_next;
    count_t               idx_reg,    idx_next;

    logic [LEN_W-1:0]  len_clamp;
    logic [LEN_W-1:0]  len_half;
    logic              key_eq;
    logic              key_lt;
    logic              second;
    logic [ADDR_W-1:0] first_addr;
    logic [ADDR_W-1:0] second_addr;
    logic [ADDR_W-1:0] next_base;
    logic [ADDR_W-1:0] next_addr;
    logic              is_lookup;
    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign is_lookup   = (item.opcode == OP_LOOKUP);
    assign len_clamp   = (32'(entry_count) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                               : LEN_W'(entry_count);
    assign len_half    = len_reg >> 1;
    assign key_eq      = (rdata_reg == key_reg);
    assign key_lt      = (rdata_reg < key_reg);
    assign second      = key_lt & len_reg[0];
    assign first_addr  = ADDR_W'(len_clamp >> 1);
    assign second_addr = mid_reg + ADDR_W'(len_half);
    assign next_base   = (state_reg == ST_PROBE && key_lt) ? mid_reg : base_reg;
    assign next_addr   = next_base + ADDR_W'(len_half >> 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start && is_lookup) begin
                    state_next = (len_clamp == '0) ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (key_eq) begin
                    state_next = ST_DONE;
                end else if (second) begin
                    state_next = ST_PROBE2;
                end else if (len_half == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_PROBE2: begin
                if (key_eq || len_half == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        key_next   = key_reg;
        base_next  = base_reg;
        mid_next   = mid_reg;
        len_next   = len_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start && is_lookup) begin
                    key_next   = KEY_WIDTH'(item.key_value);
                    base_next  = '0;
                    len_next   = len_clamp;
                    mid_next   = first_addr;
                    found_next = 1'b0;
                    idx_next   = entry_count;
                end
            end
            ST_PROBE: begin
                if (key_eq) begin
                    found_next = 1'b1;
                    idx_next   = CNT_W'(mid_reg);
                end else if (second) begin
                    base_next = mid_reg;
                    mid_next  = second_addr;
                end else begin
                    base_next = next_base;
                    len_next  = len_half;
                    mid_next  = next_addr;
                end
            end
            ST_PROBE2: begin
                if (key_eq) begin
                    found_next = 1'b1;
                    idx_next   = CNT_W'(mid_reg);
                end else begin
                    len_next = len_half;
                    mid_next = next_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mem_we           = (state_reg == ST_IDLE) && start && !is_lookup
                           && (32'(item.slot) < 32'(TABLE_DEPTH));
        rd_en            = (state_next == ST_PROBE) || (state_next == ST_PROBE2);
        rd_addr          = mid_next;
        status.idle      = (state_reg == ST_IDLE);
        status.res_valid = (state_reg == ST_DONE);
        result.found       = found_reg;
        result.match_index = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ADDR_W'(item.slot)] <= KEY_WIDTH'(item.key_value);
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        base_reg  <= base_next;
        mid_reg   <= mid_next;
        len_reg   <= len_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
    end

endmodule

/* rtl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search
// A write beat stores one key at a slot of a 1024-entry key memory; a lookup
// beat searches the first entry_count keys, which must be sorted ascending,
// and returns one result beat with found and match_index (entry_count on a
// miss). A write beat leaves the engine idle. A lookup is started, makes its
// memory probes one at a time through the single read port of the key memory
// and hands the result to the output register; no new beat is taken until it
// is through. Each halving pass makes one or two probes, so the worst case is
// an entry count of 1023 with twenty probes. A new beat is accepted while a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  stbs_pkg::count_t    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  stbs_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stbs_pkg::out_beat_t m_data
);
    import stbs_pkg::*;

    count_t      entry_count_reg;
    logic        m_valid_reg,  m_valid_next;
    out_beat_t   m_data_reg,   m_data_next;

    eng_status_t status;
    out_beat_t   result;
    logic        start;
    logic        res_ready;

    assign s_ready   = status.idle;
    assign start     = s_valid & s_ready;
    assign res_ready = !m_valid_reg || m_ready;

    stbs_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .item        (s_data),
        .entry_count (entry_count_reg),
        .res_ready   (res_ready),
        .status      (status),
        .result      (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = status.res_valid;
            if (status.res_valid) begin
                m_data_next = result;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                entry_count_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // A write beat never starts a search, so the block is ready again next cycle.
    `STBS_ASSERT(a_write_single_cycle, aclk, aresetn, (start && s_data.opcode == OP_WRITE) |=> s_ready)

    // A hit always lies inside the searched part of the table.
    `STBS_ASSERT(a_hit_in_range, aclk, aresetn, (m_valid && m_data.found) |-> (m_data.match_index < entry_count_reg))

    // A miss reports the entry count itself.
    `STBS_ASSERT(a_miss_index, aclk, aresetn, (m_valid && !m_data.found) |-> (m_data.match_index == entry_count_reg))

    // The engine never offers a result while it is also ready for a new beat.
    `STBS_ASSERT_NEVER(a_idle_and_done, aclk, aresetn, status.idle && status.res_valid)

endmodule
